// ----- rtl/msam_pkg.sv -----
// shared constants for the mirrored stripe address map
package msam_pkg;

    // field widths
    localparam int SECT_W  = 40;
    localparam int SU_W    = 17;
    localparam int WID_W   = 7;
    localparam int CHUNK_W = 6;
    localparam int PROD_W  = SU_W + WID_W;
    localparam int OUT_W   = 112;

    // configuration register indexes
    localparam logic [2:0] REG_SU    = 3'd0;
    localparam logic [2:0] REG_WIDTH = 3'd1;
    localparam logic [2:0] REG_SLOT  = 3'd2;
    localparam logic [2:0] REG_META  = 3'd3;
    localparam logic [2:0] REG_BLEND = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SECTOR  = 2'd1;
    localparam logic [1:0] ST_STRIPE  = 2'd2;

    // unit size limits
    localparam logic [SU_W-1:0] SU_MAX = 17'd65536;

endpackage

// ----- rtl/msam_div.sv -----
// pipelined restoring divider, one quotient bit per stage, with sideband
module msam_div
    import msam_pkg::*;
#(
    parameter int NW = 40,
    parameter int DW = 17,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem,
    output logic [SW-1:0] o_side
);

    logic          r_vld  [NW];
    logic [NW-1:0] r_numq [NW];
    logic [DW-1:0] r_rem  [NW];
    logic [DW-1:0] r_den  [NW];
    logic [SW-1:0] r_side [NW];

    for (genvar g = 0; g < NW; g++) begin : g_st
        logic          p_vld;
        logic [NW-1:0] p_numq;
        logic [DW-1:0] p_rem;
        logic [DW-1:0] p_den;
        logic [SW-1:0] p_side;
        logic [DW:0]   t;
        logic [DW:0]   diff;
        logic          ge;

        // stage inputs come from the ports or the previous stage
        if (g == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_numq = i_num;
            assign p_rem  = '0;
            assign p_den  = i_den;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[g-1];
            assign p_numq = r_numq[g-1];
            assign p_rem  = r_rem[g-1];
            assign p_den  = r_den[g-1];
            assign p_side = r_side[g-1];
        end

        // shift in the next dividend bit and try a subtract
        assign t    = {p_rem, p_numq[NW-1]};
        assign ge   = (t >= {1'b0, p_den});
        assign diff = t - {1'b0, p_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_numq[g] <= {p_numq[NW-2:0], ge};
                r_rem[g]  <= ge ? diff[DW-1:0] : t[DW-1:0];
                r_den[g]  <= p_den;
                r_side[g] <= p_side;
            end
        end
    end

    assign o_vld  = r_vld[NW-1];
    assign o_quo  = r_numq[NW-1];
    assign o_rem  = r_rem[NW-1];
    assign o_side = r_side[NW-1];

endmodule

// ----- rtl/mirrored_stripe_address_map.sv -----
// top level of the mirrored stripe address map
//
// Usage: requests arrive on the s_axis channel (tdata = sector position,
// tuser = access kind, 1 for a data access that adds the metadata size).
// Each request gives one result on m_axis: both mirror locations as chunk
// and sector, the run length left in the striping unit, and a status in
// tuser (ok, sector beyond area, stripe beyond slot).
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
// no request is in flight.
// The pipeline is one input stage, three chained 40-step restoring
// dividers (position by unit size, unit by width, stripe by width and
// width minus one, with slot by width times unit size alongside the first),
// one stage for the chunk rotation and one for the sector multiply into the
// output register. One request is accepted each cycle the pipeline moves.
// Reset returns the registers to their defaults and empties the pipeline.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready drops; nothing is lost or repeated.
module mirrored_stripe_address_map
    import msam_pkg::*;
#(
    parameter int MAX_WIDTH   = 64,
    parameter int SECTOR_BITS = 40
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [SECT_W-1:0] i_cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // sector_in_slot[39:0]
    input  logic [39:0]       s_axis_tdata,
    // func[0]
    input  logic [0:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // first_chunk[5:0], first_sector[45:6], second_chunk[51:46],
    // second_sector[91:52], run_length[108:92], zero fill[111:109]
    output logic [OUT_W-1:0]  m_axis_tdata,
    // status[1:0]
    output logic [1:0]        m_axis_tuser
);

    localparam int SB = (SECTOR_BITS < SECT_W) ? SECTOR_BITS : SECT_W;
    localparam logic [SECT_W-1:0] SMASK = SECT_W'((41'd1 << SB) - 41'd1);
    localparam int S2W = 1 + SU_W + SECT_W;
    localparam int S3W = S2W + SECT_W + WID_W;

    // configuration registers
    logic [SU_W-1:0]   r_su;
    logic [WID_W-1:0]  r_w;
    logic [SECT_W-1:0] r_slot;
    logic [SECT_W-1:0] r_meta;
    logic              r_blend;
    logic [PROD_W-1:0] r_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_su    <= 17'd64;
            r_w     <= 7'd4;
            r_slot  <= 40'd1048576;
            r_meta  <= '0;
            r_blend <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SU:    r_su    <= i_cfg_data[SU_W-1:0];
                REG_WIDTH: r_w     <= i_cfg_data[WID_W-1:0];
                REG_SLOT:  r_slot  <= i_cfg_data;
                REG_META:  r_meta  <= i_cfg_data;
                REG_BLEND: r_blend <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamped unit size and width
    logic [SU_W-1:0]  su_c;
    logic [WID_W-1:0] w_c;
    logic [WID_W-1:0] wm1_c;

    always_comb begin
        if (r_su == '0) su_c = 17'd1;
        else if (r_su > SU_MAX) su_c = SU_MAX;
        else su_c = r_su;
        if (r_w < 7'd2) w_c = 7'd2;
        else if (32'(r_w) > MAX_WIDTH) w_c = WID_W'(MAX_WIDTH);
        else w_c = r_w;
        wm1_c = w_c - 7'd1;
    end

    // sectors in one full stripe
    always_ff @(posedge i_clk) begin
        r_d <= {{WID_W{1'b0}}, su_c} * {{SU_W{1'b0}}, w_c};
    end

    // whole pipeline moves unless a result waits for the receiver
    logic adv;
    logic r_o_vld;
    assign adv           = !r_o_vld || m_axis_tready;
    assign s_axis_tready = adv;

    // input stage: metadata offset and area check
    logic [SECT_W:0]   pos41;
    logic              r_a_vld;
    logic [SECT_W-1:0] r_a_pos;
    logic              r_a_err;

    assign pos41 = {1'b0, s_axis_tdata} + (s_axis_tuser[0] ? {1'b0, r_meta} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (adv) begin
            r_a_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_pos <= pos41[SECT_W-1:0];
            r_a_err <= (pos41 >= {1'b0, r_slot});
        end
    end

    // position by unit size, slot by stripe size
    logic              b_vld;
    logic [SECT_W-1:0] b_unit;
    logic [SU_W-1:0]   b_off;
    logic [0:0]        b_err;
    logic              b0_vld;
    logic [SECT_W-1:0] b_lstr;

    msam_div #(.NW(SECT_W), .DW(SU_W), .SW(1)) u_div_unit (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (adv),
        .i_vld  (r_a_vld),
        .i_num  (r_a_pos),
        .i_den  (su_c),
        .i_side (r_a_err),
        .o_vld  (b_vld),
        .o_quo  (b_unit),
        .o_rem  (b_off),
        .o_side (b_err)
    );

    msam_div #(.NW(SECT_W), .DW(PROD_W), .SW(1)) u_div_lstr (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (adv),
        .i_vld  (r_a_vld),
        .i_num  (r_slot),
        .i_den  (r_d),
        .i_side (1'b0),
        .o_vld  (b0_vld),
        .o_quo  (b_lstr),
        .o_rem  (),
        .o_side ()
    );

    // unit by width: stripe and original chunk
    logic              c_vld;
    logic [SECT_W-1:0] c_stripe;
    logic [WID_W-1:0]  c_c1;
    logic [S2W-1:0]    c_side;

    msam_div #(.NW(SECT_W), .DW(WID_W), .SW(S2W)) u_div_stripe (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (adv),
        .i_vld  (b_vld && b0_vld),
        .i_num  (b_unit),
        .i_den  (w_c),
        .i_side ({b_err, b_off, b_lstr}),
        .o_vld  (c_vld),
        .o_quo  (c_stripe),
        .o_rem  (c_c1),
        .o_side (c_side)
    );

    // stripe modulo width and width minus one
    logic              d_vld;
    logic [WID_W-1:0]  d_ra;
    logic [WID_W-1:0]  d_rb;
    logic [S3W-1:0]    d_side;

    msam_div #(.NW(SECT_W), .DW(WID_W), .SW(S3W)) u_div_rot (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (adv),
        .i_vld  (c_vld),
        .i_num  (c_stripe),
        .i_den  (w_c),
        .i_side ({c_side, c_stripe, c_c1}),
        .o_vld  (d_vld),
        .o_quo  (),
        .o_rem  (d_ra),
        .o_side (d_side)
    );

    msam_div #(.NW(SECT_W), .DW(WID_W), .SW(1)) u_div_shift (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (adv),
        .i_vld  (c_vld),
        .i_num  (c_stripe),
        .i_den  (wm1_c),
        .i_side (1'b0),
        .o_vld  (),
        .o_quo  (),
        .o_rem  (d_rb),
        .o_side ()
    );

    // unpack the sideband
    logic              d_err;
    logic [SU_W-1:0]   d_off;
    logic [SECT_W-1:0] d_lstr;
    logic [SECT_W-1:0] d_stripe;
    logic [WID_W-1:0]  d_c1;

    assign {d_err, d_off, d_lstr, d_stripe, d_c1} = d_side;

    // chunk rotation, mirror stripe and status
    logic [WID_W:0]    a8, b8, c2, e8, ch1, ch2;
    logic [SECT_W-1:0] s1, s2;
    logic [1:0]        st;

    always_comb begin
        a8  = {1'b0, d_c1} + {1'b0, d_ra};
        ch1 = (a8 >= {1'b0, w_c}) ? a8 - {1'b0, w_c} : a8;
        b8  = {1'b0, d_c1} + {1'b0, d_rb} + 8'd1;
        c2  = (b8 >= {1'b0, w_c}) ? b8 - {1'b0, w_c} : b8;
        e8  = c2 + {1'b0, d_ra};
        ch2 = (e8 >= {1'b0, w_c}) ? e8 - {1'b0, w_c} : e8;
        if (r_blend) begin
            s1 = {d_stripe[SECT_W-2:0], 1'b0};
            s2 = {d_stripe[SECT_W-2:0], 1'b1};
        end else begin
            s1 = d_stripe;
            s2 = d_stripe + d_lstr;
        end
        if (d_err) st = ST_SECTOR;
        else if (d_stripe >= d_lstr) st = ST_STRIPE;
        else st = ST_OK;
    end

    logic              r_e_vld;
    logic [CHUNK_W-1:0] r_e_ch1, r_e_ch2;
    logic [SECT_W-1:0] r_e_s1, r_e_s2;
    logic [SU_W-1:0]   r_e_off;
    logic [1:0]        r_e_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (adv) begin
            r_e_vld <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e_ch1 <= ch1[CHUNK_W-1:0];
            r_e_ch2 <= ch2[CHUNK_W-1:0];
            r_e_s1  <= s1;
            r_e_s2  <= s2;
            r_e_off <= d_off;
            r_e_st  <= st;
        end
    end

    // sector multiply and output register
    logic [SECT_W+SU_W-1:0] p1, p2;
    logic [SECT_W-1:0]      n_sec1, n_sec2;
    logic [SU_W-1:0]        n_run;
    logic [OUT_W-1:0]       r_o_data;
    logic [1:0]             r_o_st;

    always_comb begin
        p1     = {{SU_W{1'b0}}, r_e_s1} * {{SECT_W{1'b0}}, su_c};
        p2     = {{SU_W{1'b0}}, r_e_s2} * {{SECT_W{1'b0}}, su_c};
        n_sec1 = (p1[SECT_W-1:0] + {{(SECT_W-SU_W){1'b0}}, r_e_off}) & SMASK;
        n_sec2 = (p2[SECT_W-1:0] + {{(SECT_W-SU_W){1'b0}}, r_e_off}) & SMASK;
        n_run  = su_c - r_e_off;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (adv) begin
            r_o_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_st <= r_e_st;
            if (r_e_st == ST_OK) begin
                r_o_data <= {3'b000, n_run, n_sec2, r_e_ch2, n_sec1, r_e_ch1};
            end else begin
                r_o_data <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_st;

endmodule

// ----- rtl/msam_checker.sv -----
// port-level checks for the mirrored stripe address map, bound to the top
module msam_checker
    import msam_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_cfg_we,
    input logic [2:0]        i_cfg_idx,
    input logic [SECT_W-1:0] i_cfg_data,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic [39:0]       s_axis_tdata,
    input logic [0:0]        s_axis_tuser,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [OUT_W-1:0]  m_axis_tdata,
    input logic [1:0]        m_axis_tuser
);

    // a waiting result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // error results carry no location
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
        else $error("error result with nonzero fields");

    // a good result always has sectors left in the unit
    a_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_OK) |-> (m_axis_tdata[108:92] != '0))
        else $error("zero run length on good result");

    // input stalls only while a result is held back
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

endmodule

bind mirrored_stripe_address_map msam_checker u_msam_checker (.*);
